// ----- design/gic_pkg.sv -----
// gic_pkg: shared types, constants and helpers of the gamepad input conditioner
// used by the front, queue, divider, back end and top level; depends on nothing
`timescale 1ns / 1ps
package gic_pkg;

  // field widths
  localparam int unsigned BtnW    = 14;
  localparam int unsigned AxisW   = 16;
  localparam int unsigned TrigW   = 9;
  localparam int unsigned CntW    = 16;
  localparam int unsigned LimW    = 15;
  localparam int unsigned SqW     = 32;
  localparam int unsigned RootW   = 16;
  localparam int unsigned ProdW   = 31;

  // serial divider shape
  localparam int unsigned DivNW   = 48;
  localparam int unsigned DivDW   = 33;
  localparam int unsigned DivQW   = 17;

  // job queue shape
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QAw     = $clog2(QDepth);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STICK_INNER = 3'd0,
    CFG_STICK_OUTER = 3'd1,
    CFG_TRIG_THR    = 3'd2,
    CFG_TRIG_SPAN   = 3'd3,
    CFG_DIR_THR     = 3'd4
  } gic_cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [LimW-1:0]  InnerRst   = 15'd7864;
  localparam logic [LimW-1:0]  OuterRst   = 15'd32767;
  localparam logic [TrigW-1:0] TrigThrRst = 9'd30;
  localparam logic [TrigW-1:0] SpanRst    = 9'd225;
  localparam logic [LimW-1:0]  DirThrRst  = 15'd9830;

  typedef struct packed {
    logic [LimW-1:0]  stick_inner;
    logic [LimW-1:0]  stick_outer;
    logic [TrigW-1:0] trig_thr;
    logic [TrigW-1:0] trig_span;
    logic [LimW-1:0]  dir_thr;
  } gic_cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [BtnW-1:0]  levels;
    logic [BtnW-1:0]  presses;
    logic [CntW-1:0]  idle_any;
    logic [CntW-1:0]  idle_confirm;
    logic             phase;
    logic [AxisW-1:0] lx;
    logic [AxisW-1:0] ly;
    logic [AxisW-1:0] rx;
    logic [AxisW-1:0] ry;
    logic [SqW-1:0]   s_l;
    logic [SqW-1:0]   s_r;
    logic [1:0]       trig_zero;
    logic [1:0]       trig_sat;
    logic [TrigW-1:0] ltd;
    logic [TrigW-1:0] rtd;
  } gic_job_t;

  // one finished result
  typedef struct packed {
    logic [BtnW-1:0]  button_levels;
    logic [BtnW-1:0]  new_presses;
    logic [CntW-1:0]  idle_any_count;
    logic [CntW-1:0]  idle_confirm_count;
    logic [AxisW-1:0] left_x;
    logic [AxisW-1:0] left_y;
    logic [AxisW-1:0] right_x;
    logic [AxisW-1:0] right_y;
    logic [AxisW-1:0] left_trigger;
    logic [AxisW-1:0] right_trigger;
    logic [7:0]       stick_directions;
    logic             frame_phase;
  } gic_res_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_PREP,
    ST_MUL,
    ST_DGO,
    ST_TRIG,
    ST_DWAIT,
    ST_OUT
  } gic_state_e;

  // direction flags of one stick: up, down, left, right
  function automatic logic [3:0] gic_dir(input logic [AxisW-1:0] x,
                                         input logic [AxisW-1:0] y,
                                         input logic [LimW-1:0]  th);
    logic signed [AxisW:0] sx;
    logic signed [AxisW:0] sy;
    logic signed [AxisW:0] pt;
    logic signed [AxisW:0] nt;
    sx = $signed({x[AxisW-1], x});
    sy = $signed({y[AxisW-1], y});
    pt = $signed({2'b00, th});
    nt = -pt;
    gic_dir = {sx > pt, sx < nt, sy < nt, sy > pt};
  endfunction

endpackage

// ----- design/gic_if.sv -----
// gic_if: valid/ready channel interfaces of the gamepad input conditioner
// input item, result item and configuration write; depends on nothing
`timescale 1ns / 1ps
interface gic_in_if;
  logic              valid;
  logic              ready;
  logic [13:0]       buttons;
  logic signed [15:0] left_x_raw;
  logic signed [15:0] left_y_raw;
  logic signed [15:0] right_x_raw;
  logic signed [15:0] right_y_raw;
  logic [8:0]        left_trigger_raw;
  logic [8:0]        right_trigger_raw;

  modport source(output valid, buttons, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
                 left_trigger_raw, right_trigger_raw, input ready);
  modport sink(input valid, buttons, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
               left_trigger_raw, right_trigger_raw, output ready);
endinterface

interface gic_out_if;
  logic              valid;
  logic              ready;
  logic [13:0]       button_levels;
  logic [13:0]       new_presses;
  logic [15:0]       idle_any_count;
  logic [15:0]       idle_confirm_count;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic [15:0]       left_trigger;
  logic [15:0]       right_trigger;
  logic [7:0]        stick_directions;
  logic              frame_phase;

  modport source(output valid, button_levels, new_presses, idle_any_count,
                 idle_confirm_count, left_x, left_y, right_x, right_y, left_trigger,
                 right_trigger, stick_directions, frame_phase, input ready);
  modport sink(input valid, button_levels, new_presses, idle_any_count,
               idle_confirm_count, left_x, left_y, right_x, right_y, left_trigger,
               right_trigger, stick_directions, frame_phase, output ready);
endinterface

interface gic_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- design/gic_front.sv -----
// gic_front: accepts input items, tracks buttons, idle counters and phase,
// squares the stick axes and classifies triggers; uses gic_pkg and gic_if
`timescale 1ns / 1ps
module gic_front
  import gic_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gic_in_if.sink     in_if,
  input  gic_cfg_t   cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output gic_job_t   job_o
);

  logic [BtnW-1:0] prev_q, prev_d;
  logic [CntW-1:0] any_q, any_d;
  logic [CntW-1:0] conf_q, conf_d;
  logic            phase_q, phase_d;
  logic [BtnW-1:0] pressed;
  logic signed [SqW-1:0] lxx, lyy, rxx, ryy;
  logic [TrigW-1:0] ltd, rtd;
  logic            lzero, rzero;

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  // new presses and saturating idle counters
  always_comb begin
    pressed = in_if.buttons & ~prev_q;
    prev_d  = in_if.buttons;
    phase_d = !phase_q;
    if (|pressed[7:0]) begin
      any_d = '0;
    end else if (any_q == '1) begin
      any_d = any_q;
    end else begin
      any_d = any_q + 1'b1;
    end
    if (pressed[0] || pressed[2]) begin
      conf_d = '0;
    end else if (conf_q == '1) begin
      conf_d = conf_q;
    end else begin
      conf_d = conf_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      any_q   <= '0;
      conf_q  <= '0;
      phase_q <= 1'b0;
    end else if (push_o) begin
      prev_q  <= prev_d;
      any_q   <= any_d;
      conf_q  <= conf_d;
      phase_q <= phase_d;
    end
  end

  // squared stick magnitudes
  assign lxx = in_if.left_x_raw * in_if.left_x_raw;
  assign lyy = in_if.left_y_raw * in_if.left_y_raw;
  assign rxx = in_if.right_x_raw * in_if.right_x_raw;
  assign ryy = in_if.right_y_raw * in_if.right_y_raw;

  // trigger classification
  assign lzero = in_if.left_trigger_raw <= cfg_i.trig_thr;
  assign rzero = in_if.right_trigger_raw <= cfg_i.trig_thr;
  assign ltd   = in_if.left_trigger_raw - cfg_i.trig_thr;
  assign rtd   = in_if.right_trigger_raw - cfg_i.trig_thr;

  always_comb begin
    job_o.levels       = in_if.buttons;
    job_o.presses      = pressed;
    job_o.idle_any     = any_d;
    job_o.idle_confirm = conf_d;
    job_o.phase        = phase_d;
    job_o.lx           = in_if.left_x_raw;
    job_o.ly           = in_if.left_y_raw;
    job_o.rx           = in_if.right_x_raw;
    job_o.ry           = in_if.right_y_raw;
    job_o.s_l          = $unsigned(lxx) + $unsigned(lyy);
    job_o.s_r          = $unsigned(rxx) + $unsigned(ryy);
    job_o.trig_zero    = {rzero, lzero};
    job_o.trig_sat     = {(cfg_i.trig_span == '0) || (rtd >= cfg_i.trig_span),
                          (cfg_i.trig_span == '0) || (ltd >= cfg_i.trig_span)};
    job_o.ltd          = ltd;
    job_o.rtd          = rtd;
  end

endmodule

// ----- design/gic_fifo.sv -----
// gic_fifo: short job queue between front and back
// uses gic_pkg for the job type and depth
`timescale 1ns / 1ps
module gic_fifo
  import gic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  gic_job_t data_i,
  input  logic     pop_i,
  output gic_job_t data_o,
  output logic     full_o,
  output logic     empty_o
);

  gic_job_t         mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QAw:0]     cnt_q;

  assign full_o  = cnt_q == QAw'(0) + (QAw+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QAw'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QAw'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/gic_div.sv -----
// gic_div: serial restoring divider, one quotient bit per cycle
// uses gic_pkg for its widths; quotient must fit DivQW bits
`timescale 1ns / 1ps
module gic_div
  import gic_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [DivQW-1:0] quo_o
);

  localparam int unsigned CntW2 = $clog2(DivQW);

  logic [DivDW-1:0] rem_q, den_q;
  logic [DivQW-1:0] lo_q;
  logic [CntW2-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DivDW:0]   sh, diff;
  logic             ge;

  // one restoring step
  assign sh   = {rem_q, lo_q[DivQW-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  assign done_o = done_q;
  assign quo_o  = lo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DivDW'(num_i[DivNW-1:DivQW]);
      lo_q  <= num_i[DivQW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDW-1:0] : sh[DivDW-1:0];
      lo_q  <= {lo_q[DivQW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW2'(DivQW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/gic_back.sv -----
// gic_back: per item sequencer: stick square roots, deadzone scaling and
// trigger scaling through one shared divider, then the output register
// uses gic_pkg, gic_if and gic_div
`timescale 1ns / 1ps
module gic_back
  import gic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gic_cfg_t  cfg_i,
  input  logic      empty_i,
  input  gic_job_t  job_i,
  output logic      pop_o,
  gic_out_if.source out_if
);

  gic_state_e state_q, state_d;
  gic_job_t   ent_q;
  logic [2:0] job_q, job_d;

  logic [SqW-1:0]   sval_q;
  logic [RootW-1:0] root_q;
  logic [17:0]      srem_q;
  logic [3:0]       scnt_q;
  logic             sq_load, sq_from_in;
  logic [19:0]      rem_sh, trial, rdiff;
  logic             sq_ge;

  logic [LimW-1:0]  k_q, w_q, e_val;
  logic [ProdW-1:0] pa_q, pb_q;
  logic             unit, dead;
  logic [AxisW-1:0] cur_c, abs_c;
  logic             c_neg;

  logic             div_start, div_done, trig_mode;
  logic [DivNW-1:0] div_num;
  logic [DivDW-1:0] div_den;
  logic [DivQW-1:0] div_q, qs, qneg;
  logic [TrigW-1:0] tdiff;

  logic [AxisW-1:0] res_q [6];
  logic             res_we, clr_pair;
  logic [AxisW-1:0] res_val, dval;

  gic_res_t out_q;
  logic     out_valid_q, out_load;

  // operand selection for the current job
  always_comb begin
    case (job_q[1:0])
      2'd0:    cur_c = ent_q.lx;
      2'd1:    cur_c = ent_q.ly;
      2'd2:    cur_c = ent_q.rx;
      default: cur_c = ent_q.ry;
    endcase
    c_neg = cur_c[AxisW-1];
    abs_c = c_neg ? (AxisW'(0) - cur_c) : cur_c;
    unit  = cfg_i.stick_outer <= cfg_i.stick_inner;
    e_val = (root_q < {1'b0, cfg_i.stick_outer}) ? root_q[LimW-1:0] : cfg_i.stick_outer;
    dead  = (root_q < {1'b0, cfg_i.stick_inner}) ||
            ((root_q == {1'b0, cfg_i.stick_inner}) && (srem_q == '0));
    tdiff = job_q[0] ? ent_q.rtd : ent_q.ltd;
  end

  // square root step, two radicand bits a cycle
  assign rem_sh = {srem_q, sval_q[SqW-1:SqW-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign rdiff  = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (sq_load) begin
      sval_q <= sq_from_in ? job_i.s_l : ent_q.s_r;
      root_q <= '0;
      srem_q <= '0;
      scnt_q <= 4'd15;
    end else if (state_q == ST_SQRT) begin
      sval_q <= {sval_q[SqW-3:0], 2'b00};
      srem_q <= sq_ge ? rdiff[17:0] : rem_sh[17:0];
      root_q <= {root_q[RootW-2:0], sq_ge};
      scnt_q <= scnt_q - 1'b1;
    end
  end

  // scale factors and products
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= job_i;
    end
    if (state_q == ST_PREP) begin
      k_q <= unit ? LimW'(1) : (e_val - cfg_i.stick_inner);
      w_q <= unit ? LimW'(1) : (cfg_i.stick_outer - cfg_i.stick_inner);
    end
    if (state_q == ST_MUL) begin
      pa_q <= abs_c * k_q;
      pb_q <= root_q * w_q;
    end
  end

  // divider operands
  always_comb begin
    if (trig_mode) begin
      div_num = DivNW'({tdiff, 17'd0}) + DivNW'(cfg_i.trig_span);
      div_den = DivDW'({cfg_i.trig_span, 1'b0});
    end else begin
      div_num = DivNW'({pa_q, 16'd0}) + DivNW'(pb_q);
      div_den = DivDW'({pb_q, 1'b0});
    end
  end

  gic_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // quotient to output code, saturated for stick components
  always_comb begin
    qs   = (div_q > DivQW'(32768)) ? DivQW'(32768) : div_q;
    qneg = DivQW'(0) - qs;
    if (job_q[2]) begin
      dval = div_q[AxisW-1:0];
    end else if (c_neg) begin
      dval = qneg[AxisW-1:0];
    end else begin
      dval = (div_q > DivQW'(32767)) ? 16'h7FFF : div_q[AxisW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    pop_o      = 1'b0;
    sq_load    = 1'b0;
    sq_from_in = 1'b0;
    div_start  = 1'b0;
    trig_mode  = job_q[2];
    res_we     = 1'b0;
    res_val    = dval;
    clr_pair   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          sq_load    = 1'b1;
          sq_from_in = 1'b1;
          job_d      = 3'd0;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (scnt_q == '0) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (dead) begin
          clr_pair = 1'b1;
          job_d    = job_q + 3'd2;
          if (job_q == 3'd0) begin
            sq_load = 1'b1;
            state_d = ST_SQRT;
          end else begin
            state_d = ST_TRIG;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DGO;
      end
      ST_DGO: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_TRIG: begin
        if (ent_q.trig_zero[job_q[0]] || ent_q.trig_sat[job_q[0]]) begin
          res_we  = 1'b1;
          res_val = ent_q.trig_zero[job_q[0]] ? '0 : '1;
          job_d   = job_q + 1'b1;
          state_d = (job_q == 3'd5) ? ST_OUT : ST_TRIG;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          res_we = 1'b1;
          job_d  = job_q + 1'b1;
          case (job_q)
            3'd0, 3'd2: state_d = ST_MUL;
            3'd1: begin
              sq_load = 1'b1;
              state_d = ST_SQRT;
            end
            3'd3, 3'd4: state_d = ST_TRIG;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  // per job results
  always_ff @(posedge clk_i) begin
    if (clr_pair) begin
      res_q[{job_q[2:1], 1'b0}] <= '0;
      res_q[{job_q[2:1], 1'b1}] <= '0;
    end else if (res_we) begin
      res_q[job_q] <= res_val;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.button_levels      <= ent_q.levels;
      out_q.new_presses        <= ent_q.presses;
      out_q.idle_any_count     <= ent_q.idle_any;
      out_q.idle_confirm_count <= ent_q.idle_confirm;
      out_q.left_x             <= res_q[0];
      out_q.left_y             <= res_q[1];
      out_q.right_x            <= res_q[2];
      out_q.right_y            <= res_q[3];
      out_q.left_trigger       <= res_q[4];
      out_q.right_trigger      <= res_q[5];
      out_q.stick_directions   <= {gic_dir(res_q[2], res_q[3], cfg_i.dir_thr),
                                   gic_dir(res_q[0], res_q[1], cfg_i.dir_thr)};
      out_q.frame_phase        <= ent_q.phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid              = out_valid_q;
  assign out_if.button_levels      = out_q.button_levels;
  assign out_if.new_presses        = out_q.new_presses;
  assign out_if.idle_any_count     = out_q.idle_any_count;
  assign out_if.idle_confirm_count = out_q.idle_confirm_count;
  assign out_if.left_x             = out_q.left_x;
  assign out_if.left_y             = out_q.left_y;
  assign out_if.right_x            = out_q.right_x;
  assign out_if.right_y            = out_q.right_y;
  assign out_if.left_trigger       = out_q.left_trigger;
  assign out_if.right_trigger      = out_q.right_trigger;
  assign out_if.stick_directions   = out_q.stick_directions;
  assign out_if.frame_phase        = out_q.frame_phase;

endmodule

// ----- design/gamepad_input_conditioner.sv -----
// gamepad_input_conditioner: top level, configuration registers and wiring
// uses gic_pkg, gic_if, gic_front, gic_fifo, gic_back
//
// Usage: one item per gamepad poll enters on in_if (buttons, four stick axes,
// two triggers); one conditioned item leaves on out_if for each. Both are
// valid/ready channels. Configuration is written on cfg_if (index, data); the
// user must write it only while the block is idle, as the block itself does
// not enforce this. Indexes beyond the register list are ignored. The front
// takes an item whenever the two-entry job queue has room, so it keeps
// accepting while the back works or the output waits. The back handles one
// item at a time: a square root per stick, then a serial division per stick
// component when the stick is outside the deadzone and per trigger that is
// neither idle nor saturated, the divisions all sharing one divider.
// Reset clears button history, idle counters, the phase bit, the queue and the
// output valid bit, and loads the default limits. When the receiver stalls the
// result holds in the output register, the queue fills, then in_if.ready drops.
`timescale 1ns / 1ps
module gamepad_input_conditioner
  import gic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gic_in_if.sink    in_if,
  gic_out_if.source out_if,
  gic_cfg_if.sink   cfg_if
);

  gic_cfg_t cfg_q;
  gic_job_t push_data, pop_data;
  logic     push, pop, full, empty;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_inner <= InnerRst;
      cfg_q.stick_outer <= OuterRst;
      cfg_q.trig_thr    <= TrigThrRst;
      cfg_q.trig_span   <= SpanRst;
      cfg_q.dir_thr     <= DirThrRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_STICK_INNER: cfg_q.stick_inner <= cfg_if.data;
        CFG_STICK_OUTER: cfg_q.stick_outer <= cfg_if.data;
        CFG_TRIG_THR:    cfg_q.trig_thr    <= cfg_if.data[TrigW-1:0];
        CFG_TRIG_SPAN:   cfg_q.trig_span   <= cfg_if.data[TrigW-1:0];
        CFG_DIR_THR:     cfg_q.dir_thr     <= cfg_if.data;
        default: ;
      endcase
    end
  end

  gic_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (push_data)
  );

  gic_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .full_o  (full),
    .empty_o (empty)
  );

  gic_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (pop_data),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

// ----- design/gic_checker.sv -----
// gic_checker: port level checks of the gamepad input conditioner
// uses gic_if; bound to the top level below
`timescale 1ns / 1ps
module gic_checker (
  input logic      clk_i,
  input logic      rst_ni,
  gic_out_if.source out_if
);

  logic last_q, seen_q;

  // phase of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      seen_q <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      last_q <= out_if.frame_phase;
      seen_q <= 1'b1;
    end
  end

  // no output during reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_if.valid)
    else $error("output valid during reset");

  // a new press is always a held button
  a_press_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ((out_if.new_presses & ~out_if.button_levels) == 14'd0))
    else $error("new press without button level");

  // a press among the low buttons restarts the idle counter
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.new_presses[7:0] != 8'd0)) |-> (out_if.idle_any_count == 16'd0))
    else $error("idle counter not cleared by press");

  // opposite directions never both set
  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (!(out_if.stick_directions[0] && out_if.stick_directions[1]) &&
                      !(out_if.stick_directions[2] && out_if.stick_directions[3]) &&
                      !(out_if.stick_directions[4] && out_if.stick_directions[5]) &&
                      !(out_if.stick_directions[6] && out_if.stick_directions[7])))
    else $error("opposite direction flags");

  // successive items alternate phase
  a_phase_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && seen_q) |-> (out_if.frame_phase != last_q))
    else $error("frame phase did not toggle");

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_if (out_if)
);
